>>> hw/rtl/lawl_pkg.sv
// ----------------------------------------------------------------------------
// lawl_pkg
// Shared types and constants for the leaky accumulator array with winner latch.
// ----------------------------------------------------------------------------
package lawl_pkg;

    localparam int DATA_W    = 16;
    localparam int GAIN_W    = 15;
    localparam int WIN_IDX_W = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int FRAC_W    = 12;

    localparam logic signed [DATA_W-1:0] Q_ONE         = 16'sd4096;
    localparam logic signed [DATA_W-1:0] WIN_THRESHOLD = 16'sd3686;

    localparam logic [GAIN_W-1:0] EXCITE_GAIN_RST  = 15'd4096;
    localparam logic [GAIN_W-1:0] INHIBIT_GAIN_RST = 15'd4096;
    localparam logic [GAIN_W-1:0] PULL_RATE_RST    = 15'd0;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_EXCITE_GAIN  = 2'd0,
        REG_INHIBIT_GAIN = 2'd1,
        REG_PULL_RATE    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] excite_gain;
        logic [GAIN_W-1:0] inhibit_gain;
        logic [GAIN_W-1:0] pull_rate;
    } cfg_t;

    // one finished element as seen by the tick tracker
    typedef struct packed {
        logic signed [DATA_W-1:0] act;
        logic                     head;
        logic                     last;
        logic                     inh_nz;
    } elem_t;

    typedef struct packed {
        logic                 valid;
        logic [WIN_IDX_W-1:0] index;
    } win_t;

endpackage

>>> hw/rtl/lawl_req_if.sv
// ----------------------------------------------------------------------------
// lawl_req_if
// Input channel: one element of excitation and inhibition per transaction.
// ----------------------------------------------------------------------------
interface lawl_req_if import lawl_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] excite_value;
    logic signed [DATA_W-1:0] inhibit_value;

    modport source (output valid, output excite_value, output inhibit_value, input ready);
    modport sink   (input valid, input excite_value, input inhibit_value, output ready);

endinterface

>>> hw/rtl/lawl_rsp_if.sv
// ----------------------------------------------------------------------------
// lawl_rsp_if
// Result channel: updated activity and winner status per transaction.
// ----------------------------------------------------------------------------
interface lawl_rsp_if import lawl_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_activity;
    logic                     tick_end;
    logic                     winner_valid;
    logic [WIN_IDX_W-1:0]     winner_index;

    modport source (output valid, output new_activity, output tick_end,
                    output winner_valid, output winner_index, input ready);
    modport sink   (input valid, input new_activity, input tick_end,
                    input winner_valid, input winner_index, output ready);

endinterface

>>> hw/rtl/lawl_cfg.sv
// ----------------------------------------------------------------------------
// lawl_cfg
// APB register file holding the three unsigned Q3.12 gains.
// ----------------------------------------------------------------------------
module lawl_cfg import lawl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t sel;
    logic     wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign sel    = cfg_reg_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (sel)
                REG_EXCITE_GAIN:  cfg_next.excite_gain  = pwdata[GAIN_W-1:0];
                REG_INHIBIT_GAIN: cfg_next.inhibit_gain = pwdata[GAIN_W-1:0];
                REG_PULL_RATE:    cfg_next.pull_rate    = pwdata[GAIN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_EXCITE_GAIN:  prdata = PDATA_W'(cfg_reg.excite_gain);
            REG_INHIBIT_GAIN: prdata = PDATA_W'(cfg_reg.inhibit_gain);
            REG_PULL_RATE:    prdata = PDATA_W'(cfg_reg.pull_rate);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.excite_gain  <= EXCITE_GAIN_RST;
            cfg_reg.inhibit_gain <= INHIBIT_GAIN_RST;
            cfg_reg.pull_rate    <= PULL_RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/lawl_act_mem.sv
// ----------------------------------------------------------------------------
// lawl_act_mem
// Activity store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lawl_act_mem import lawl_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] ram_reg [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

endmodule

>>> hw/rtl/lawl_winner.sv
// ----------------------------------------------------------------------------
// lawl_winner
// Per-tick running maximum, inhibition flag and the latched winner.
// ----------------------------------------------------------------------------
module lawl_winner import lawl_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd,
    input  logic [IDX_W-1:0] idx,
    input  elem_t            elem,
    output win_t             win
);

    logic signed [DATA_W-1:0] max_reg, max_next;
    logic [IDX_W-1:0]         max_idx_reg, max_idx_next;
    logic                     inh_seen_reg, inh_seen_next;
    logic                     latched_reg, latched_next;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic [IDX_W+WIN_IDX_W-1:0] slot_ext;

    always_comb
    begin
        max_next      = max_reg;
        max_idx_next  = max_idx_reg;
        latched_next  = latched_reg;
        slot_next     = slot_reg;
        // element 0 restarts the maximum; ties keep the lower index
        if (elem.head || (elem.act > max_reg))
        begin
            max_next     = elem.act;
            max_idx_next = idx;
        end
        inh_seen_next = (inh_seen_reg && !elem.head) || elem.inh_nz;
        if (elem.last)
        begin
            if (inh_seen_next)
            begin
                latched_next = 1'b0;
            end
            if (!latched_next && (max_next > WIN_THRESHOLD))
            begin
                latched_next = 1'b1;
                slot_next    = max_idx_next;
            end
        end
    end

    assign slot_ext  = {{WIN_IDX_W{1'b0}}, slot_next};
    assign win.valid = latched_next;
    assign win.index = latched_next ? slot_ext[WIN_IDX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg      <= '0;
            max_idx_reg  <= '0;
            inh_seen_reg <= 1'b0;
            latched_reg  <= 1'b0;
            slot_reg     <= '0;
        end
        else if (upd)
        begin
            max_reg      <= max_next;
            max_idx_reg  <= max_idx_next;
            inh_seen_reg <= inh_seen_next;
            latched_reg  <= latched_next;
            slot_reg     <= slot_next;
        end
    end

endmodule

>>> hw/rtl/leaky_accumulator_winner_latch_top.sv
// ----------------------------------------------------------------------------
// leaky_accumulator_winner_latch_top
// Array of leaky accumulators streamed one element per transaction, with a
// per-tick first-index maximum and a latched winner.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | valid / ready          | excite_value, inhibit_value
//  rsp     | out | valid / ready          | new_activity, tick_end,
//          |     |                        | winner_valid, winner_index
//  apb     | in  | psel, penable, pready  | paddr, pwdata, prdata
//
//  one transaction per cycle sustained while rsp is ready
//  stages: store read, three gain products, sum/saturate into the rsp register
//  a store write that lands on the element held in the read stage is forwarded
//  the first tick after reset reads activity as zero (no clearing pass)
//  rsp backpressure stalls the stages in order, holes fill while stalled
// ----------------------------------------------------------------------------
module leaky_accumulator_winner_latch_top import lawl_pkg::*;
#(
    parameter int UNITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    lawl_req_if.sink           req,
    lawl_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int               IDX_W    = $clog2(UNITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(UNITS - 1);

    cfg_t cfg;

    // stage control
    logic a_v_reg, b_v_reg, out_v_reg;
    logic out_adv, b_adv, a_adv;
    logic req_fire, ab_fire, c_fire;

    // element counter and first-tick mark
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             first_tick_reg;

    // read stage
    logic signed [DATA_W-1:0] a_exc_reg, a_inh_reg;
    logic [IDX_W-1:0]         a_idx_reg;
    logic                     a_fresh_reg;
    logic signed [DATA_W-1:0] rd_data;
    logic                     fwd_v_reg, fwd_v_next;
    logic signed [DATA_W-1:0] fwd_data_reg;
    logic [IDX_W-1:0]         fwd_target;
    logic                     fwd_hit;
    logic signed [DATA_W-1:0] a_act;
    logic signed [DATA_W:0]   pull_diff;
    logic signed [31:0]       prod_e, prod_i;
    logic signed [32:0]       prod_p;

    // product stage
    logic signed [31:0]       b_pe_reg, b_pi_reg;
    logic signed [32:0]       b_pp_reg;
    logic signed [DATA_W-1:0] b_act_reg;
    logic [IDX_W-1:0]         b_idx_reg;
    logic                     b_inh_nz_reg;

    // sum stage
    logic signed [19:0]       term_e, term_i;
    logic signed [20:0]       term_p;
    logic signed [22:0]       sum;
    logic signed [DATA_W-1:0] new_act;
    elem_t                    elem;
    win_t                     win;

    // rsp register
    logic signed [DATA_W-1:0] out_act_reg;
    logic                     out_last_reg;
    win_t                     out_win_reg;

    lawl_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_adv   = !out_v_reg || rsp.ready;
    assign b_adv     = !b_v_reg || out_adv;
    assign a_adv     = !a_v_reg || b_adv;
    assign req.ready = a_adv;
    assign req_fire  = req.valid && a_adv;
    assign ab_fire   = a_v_reg && b_adv;
    assign c_fire    = b_v_reg && out_adv;

    assign cnt_next = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;

    lawl_act_mem #(
        .DEPTH (UNITS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (c_fire),
        .waddr (b_idx_reg),
        .wdata (new_act),
        .re    (req_fire),
        .raddr (cnt_reg),
        .rdata (rd_data)
    );

    // write-back landing on the element whose read is in flight
    assign fwd_target = req_fire ? cnt_reg : a_idx_reg;
    assign fwd_hit    = c_fire && (req_fire || a_v_reg) && (b_idx_reg == fwd_target);

    always_comb
    begin
        fwd_v_next = fwd_v_reg;
        if (fwd_hit)
        begin
            fwd_v_next = 1'b1;
        end
        else if (req_fire)
        begin
            fwd_v_next = 1'b0;
        end
    end

    always_comb
    begin
        if (a_fresh_reg)
        begin
            a_act = '0;
        end
        else if (fwd_v_reg)
        begin
            a_act = fwd_data_reg;
        end
        else
        begin
            a_act = rd_data;
        end
    end

    assign pull_diff = $signed({Q_ONE[DATA_W-1], Q_ONE}) - $signed({a_act[DATA_W-1], a_act});
    assign prod_e    = $signed({1'b0, cfg.excite_gain}) * a_exc_reg;
    assign prod_i    = $signed({1'b0, cfg.inhibit_gain}) * a_inh_reg;
    assign prod_p    = $signed({1'b0, cfg.pull_rate}) * pull_diff;

    // floor shift by 12 is the upper slice of each product
    assign term_e = $signed(b_pe_reg[31:FRAC_W]);
    assign term_i = $signed(b_pi_reg[31:FRAC_W]);
    assign term_p = $signed(b_pp_reg[32:FRAC_W]);
    assign sum    = 23'(b_act_reg) + 23'(term_e) - 23'(term_i) + 23'(term_p);

    always_comb
    begin
        if (sum > 23'sd32767)
        begin
            new_act = 16'sh7fff;
        end
        else if (sum < -23'sd32768)
        begin
            new_act = 16'sh8000;
        end
        else
        begin
            new_act = sum[DATA_W-1:0];
        end
    end

    assign elem.act    = new_act;
    assign elem.head   = (b_idx_reg == '0);
    assign elem.last   = (b_idx_reg == LAST_IDX);
    assign elem.inh_nz = b_inh_nz_reg;

    lawl_winner #(
        .IDX_W (IDX_W)
    ) u_winner (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (c_fire),
        .idx   (b_idx_reg),
        .elem  (elem),
        .win   (win)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
            out_v_reg      <= 1'b0;
            cnt_reg        <= '0;
            first_tick_reg <= 1'b1;
            fwd_v_reg      <= 1'b0;
        end
        else
        begin
            fwd_v_reg <= fwd_v_next;
            if (a_adv)
            begin
                a_v_reg <= req.valid;
            end
            if (b_adv)
            begin
                b_v_reg <= a_v_reg;
            end
            if (out_adv)
            begin
                out_v_reg <= b_v_reg;
            end
            if (req_fire)
            begin
                cnt_reg <= cnt_next;
                if (cnt_reg == LAST_IDX)
                begin
                    first_tick_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            a_exc_reg   <= req.excite_value;
            a_inh_reg   <= req.inhibit_value;
            a_idx_reg   <= cnt_reg;
            a_fresh_reg <= first_tick_reg;
        end
        if (fwd_hit)
        begin
            fwd_data_reg <= new_act;
        end
        if (ab_fire)
        begin
            b_pe_reg     <= prod_e;
            b_pi_reg     <= prod_i;
            b_pp_reg     <= prod_p;
            b_act_reg    <= a_act;
            b_idx_reg    <= a_idx_reg;
            b_inh_nz_reg <= (a_inh_reg != '0);
        end
        if (c_fire)
        begin
            out_act_reg  <= new_act;
            out_last_reg <= elem.last;
            out_win_reg  <= win;
        end
    end

    assign rsp.valid        = out_v_reg;
    assign rsp.new_activity = out_act_reg;
    assign rsp.tick_end     = out_last_reg;
    assign rsp.winner_valid = out_win_reg.valid;
    assign rsp.winner_index = out_win_reg.index;

endmodule

>>> hw/rtl/lawl_checker.sv
// ----------------------------------------------------------------------------
// lawl_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lawl_checker import lawl_pkg::*;
#(
    parameter int UNITS = 16
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic signed [DATA_W-1:0] new_activity,
    input logic                     tick_end,
    input logic                     winner_valid,
    input logic [WIN_IDX_W-1:0]     winner_index
);

    localparam int               CNT_W    = $clog2(UNITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(UNITS - 1);

    logic                 rsp_fire;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 have_prev_reg;
    logic                 prev_valid_reg;
    logic [WIN_IDX_W-1:0] prev_index_reg;

    assign rsp_fire = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            have_prev_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_index_reg <= '0;
        end
        else if (rsp_fire)
        begin
            cnt_reg        <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
            have_prev_reg  <= 1'b1;
            prev_valid_reg <= winner_valid;
            prev_index_reg <= winner_index;
        end
    end

    // held result stays put while stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({new_activity, tick_end, winner_valid, winner_index}))
        else $error("rsp payload changed while stalled");

    // tick end marks every UNITS-th transaction
    a_tick_period: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> (tick_end == (cnt_reg == CNT_LAST)))
        else $error("tick_end out of step with element count");

    // winner status only moves on a tick end
    a_winner_steady: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && have_prev_reg && !tick_end
            |-> (winner_valid == prev_valid_reg) && (winner_index == prev_index_reg))
        else $error("winner changed inside a tick");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !winner_valid |-> (winner_index == '0))
        else $error("winner_index nonzero with no winner");

endmodule

bind leaky_accumulator_winner_latch_top lawl_checker #(
    .UNITS (UNITS)
) u_lawl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .new_activity (rsp.new_activity),
    .tick_end     (rsp.tick_end),
    .winner_valid (rsp.winner_valid),
    .winner_index (rsp.winner_index)
);

>>> bench/leaky_accumulator_winner_latch_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leaky_accumulator_winner_latch_top_tb
// Streams excitation/inhibition elements through the accumulator array and
// checks every result against an in-bench activity predictor or the typed
// rows of a directed table, which covers saturation, ties and the first tick
// after reset; random ticks follow under several gain settings and
// sender/receiver stall mixes, with ticks aimed at the winner threshold.
// ----------------------------------------------------------------------------
module leaky_accumulator_winner_latch_top_tb;

    import lawl_pkg::*;

    localparam int UNITS       = 16;
    localparam int DIR_ROWS    = 25;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 12 * UNITS;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [1:0]        UNUSED_REG = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
    localparam longint            ACT_MAX    = 32767;
    localparam longint            ACT_MIN    = -32768;

    typedef struct packed {
        logic signed [DATA_W-1:0] act;
        logic                     tick_end;
        logic                     win_valid;
        logic [WIN_IDX_W-1:0]     win_index;
    } activity_result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] exc;
        logic signed [DATA_W-1:0] inh;
        logic                     typed;
        activity_result_t         res;
    } stim_row_t;

    typedef struct packed {
        int               seq;
        activity_result_t res;
    } known_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lawl_req_if req_ch ();
    lawl_rsp_if rsp_ch ();

    leaky_accumulator_winner_latch_top #(.UNITS(UNITS)) DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // first tick after reset: gains 1.0, pull 0, so activity = exc - inh, clamped
    stim_row_t stim_table [DIR_ROWS] = '{
        '{16'sh7FFF, 16'sh0000, 1'b1, '{16'sh7FFF, 1'b0, 1'b0, 4'd0}},
        '{16'sh8000, 16'sh0000, 1'b1, '{16'sh8000, 1'b0, 1'b0, 4'd0}},
        '{16'sh7FFF, 16'sh8000, 1'b1, '{16'sh7FFF, 1'b0, 1'b0, 4'd0}},
        '{16'sh8000, 16'sh7FFF, 1'b1, '{16'sh8000, 1'b0, 1'b0, 4'd0}},
        '{16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, 1'b0, 1'b0, 4'd0}},
        '{16'shFFFF, 16'shFFFF, 1'b1, '{16'sh0000, 1'b0, 1'b0, 4'd0}},
        '{16'sh0001, 16'sh0000, 1'b1, '{16'sh0001, 1'b0, 1'b0, 4'd0}},
        '{16'sh0000, 16'sh0001, 1'b1, '{16'shFFFF, 1'b0, 1'b0, 4'd0}},
        '{16'sh0E66, 16'sh0000, 1'b1, '{16'sh0E66, 1'b0, 1'b0, 4'd0}},
        '{16'sh0E67, 16'sh0000, 1'b1, '{16'sh0E67, 1'b0, 1'b0, 4'd0}},
        '{16'sh5555, 16'sh2AAA, 1'b1, '{16'sh2AAB, 1'b0, 1'b0, 4'd0}},
        '{16'shAAAA, 16'shD555, 1'b1, '{16'shD555, 1'b0, 1'b0, 4'd0}},
        '{16'sh1000, 16'sh1000, 1'b1, '{16'sh0000, 1'b0, 1'b0, 4'd0}},
        '{16'sh0064, 16'shFF38, 1'b1, '{16'sh012C, 1'b0, 1'b0, 4'd0}},
        '{16'shFED4, 16'sh8000, 1'b1, '{16'sh7ED4, 1'b0, 1'b0, 4'd0}},
        // inhibition clears, then the tied maximum at element 0 is latched
        '{16'sh7FFF, 16'sh7FFF, 1'b1, '{16'sh0000, 1'b1, 1'b1, 4'd0}},
        '{16'sh0000, 16'sh0000, 1'b0, '0},
        '{16'sh0001, 16'sh8000, 1'b0, '0},
        '{16'shFFFF, 16'sh7FFF, 1'b0, '0},
        '{16'sh7FFF, 16'sh0000, 1'b0, '0},
        '{16'sh8000, 16'sh0000, 1'b0, '0},
        '{16'sh4000, 16'sh0005, 1'b0, '0},
        '{16'shC000, 16'shFFFB, 1'b0, '0},
        '{16'sh0800, 16'sh0000, 1'b0, '0},
        '{16'shF800, 16'sh0000, 1'b0, '0}
    };

    // predictor state
    cfg_t                     cfg = '{EXCITE_GAIN_RST, INHIBIT_GAIN_RST, PULL_RATE_RST};
    logic signed [DATA_W-1:0] unit_act [UNITS];
    int                       elem_pos;
    logic signed [DATA_W-1:0] run_max;
    logic [WIN_IDX_W-1:0]     run_max_idx;
    logic                     inh_seen;
    logic                     win_latched;
    logic [WIN_IDX_W-1:0]     win_slot;

    activity_result_t pending_activity [$];
    known_result_t    known_activity [$];

    // stimulus plan for one tick
    logic                     aim_mode;
    logic                     plan_noise;
    logic                     plan_quiet;
    logic signed [DATA_W-1:0] plan_exc [UNITS];
    logic signed [DATA_W-1:0] plan_inh [UNITS];
    int                       gen_pos;

    int src_idle_pct;
    int snk_idle_pct;
    int items_sent;
    int items_accepted;
    int results_checked;
    int ticks_seen;
    int winner_ticks;
    int cfg_writes;
    int mismatches;
    int quiet_cycles;

    activity_result_t predicted;
    activity_result_t expected_res;
    activity_result_t observed;
    logic             in_hs;
    logic             out_hs;

    function automatic activity_result_t predict_activity(
        input logic signed [DATA_W-1:0] exc,
        input logic signed [DATA_W-1:0] inh
    );
        activity_result_t res;
        longint           acc;
        int               slot;
        logic             at_end;
        slot = elem_pos;
        acc  = longint'(unit_act[slot])
             + ((longint'(cfg.excite_gain) * longint'(exc)) >>> FRAC_W)
             - ((longint'(cfg.inhibit_gain) * longint'(inh)) >>> FRAC_W)
             + ((longint'(cfg.pull_rate) * (longint'(Q_ONE) - longint'(unit_act[slot])))
                >>> FRAC_W);
        if (acc > ACT_MAX)
            acc = ACT_MAX;
        else if (acc < ACT_MIN)
            acc = ACT_MIN;
        unit_act[slot] = DATA_W'(acc);

        // element 0 restarts the running maximum, ties keep the lower index
        if (slot == 0 || unit_act[slot] > run_max)
        begin
            run_max     = unit_act[slot];
            run_max_idx = WIN_IDX_W'(slot);
        end
        if (slot == 0)
            inh_seen = 1'b0;
        if (inh != 0)
            inh_seen = 1'b1;

        at_end = (slot == UNITS - 1);
        if (at_end)
        begin
            if (inh_seen)
                win_latched = 1'b0;
            if (!win_latched && run_max > WIN_THRESHOLD)
            begin
                win_latched = 1'b1;
                win_slot    = run_max_idx;
            end
            elem_pos = 0;
        end
        else
        begin
            elem_pos = slot + 1;
        end

        res.act       = unit_act[slot];
        res.tick_end  = at_end;
        res.win_valid = win_latched;
        res.win_index = win_latched ? win_slot : '0;
        return res;
    endfunction

    task automatic check_activity(input activity_result_t exp_r, input activity_result_t got_r);
        if (exp_r.act !== got_r.act)
        begin
            mismatches++;
            $display("%0t: new_activity expected %0d actual %0d", $time, exp_r.act, got_r.act);
        end
        if (exp_r.tick_end !== got_r.tick_end)
        begin
            mismatches++;
            $display("%0t: tick_end expected %0d actual %0d", $time,
                     exp_r.tick_end, got_r.tick_end);
        end
        if (exp_r.win_valid !== got_r.win_valid)
        begin
            mismatches++;
            $display("%0t: winner_valid expected %0d actual %0d", $time,
                     exp_r.win_valid, got_r.win_valid);
        end
        if (exp_r.win_index !== got_r.win_index)
        begin
            mismatches++;
            $display("%0t: winner_index expected %0d actual %0d", $time,
                     exp_r.win_index, got_r.win_index);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_hs  = req_ch.valid && req_ch.ready;
            out_hs = rsp_ch.valid && rsp_ch.ready;
            if (in_hs)
            begin
                predicted = predict_activity(req_ch.excite_value, req_ch.inhibit_value);
                if (known_activity.size() != 0 && known_activity[0].seq == items_accepted)
                begin
                    predicted = known_activity[0].res;
                    void'(known_activity.pop_front());
                end
                pending_activity.push_back(predicted);
                items_accepted++;
            end
            if (out_hs)
            begin
                observed.act       = rsp_ch.new_activity;
                observed.tick_end  = rsp_ch.tick_end;
                observed.win_valid = rsp_ch.winner_valid;
                observed.win_index = rsp_ch.winner_index;
                if (pending_activity.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, new_activity %0d", $time,
                             observed.act);
                end
                else
                begin
                    expected_res = pending_activity.pop_front();
                    check_activity(expected_res, observed);
                    results_checked++;
                    if (expected_res.tick_end)
                    begin
                        ticks_seen++;
                        if (expected_res.win_valid)
                            winner_ticks++;
                    end
                end
            end
            if (in_hs || out_hs)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: random stalls plus two long hold-offs that back the block up
    initial
    begin
        int drained;
        int holds_done;
        drained    = 0;
        holds_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                drained++;
            if (holds_done < 2 && drained >= (holds_done == 0 ? 150 : 900))
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_EXCITE_GAIN:  cfg.excite_gain  = data[GAIN_W-1:0];
            REG_INHIBIT_GAIN: cfg.inhibit_gain = data[GAIN_W-1:0];
            REG_PULL_RATE:    cfg.pull_rate    = data[GAIN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_config_readback();
        logic [PDATA_W-1:0] rd [3];
        logic [PDATA_W-1:0] want [3];
        int                 k;
        want[0] = PDATA_W'(cfg.excite_gain);
        want[1] = PDATA_W'(cfg.inhibit_gain);
        want[2] = PDATA_W'(cfg.pull_rate);
        apb_read(REG_EXCITE_GAIN, rd[0]);
        apb_read(REG_INHIBIT_GAIN, rd[1]);
        apb_read(REG_PULL_RATE, rd[2]);
        for (k = 0; k < 3; k++)
        begin
            if (rd[k] !== want[k])
            begin
                mismatches++;
                $display("%0t: register %0d expected %0h actual %0h", $time, k, want[k], rd[k]);
            end
        end
    endtask

    // upper data bits are junk, the block keeps only the gain width
    task automatic apply_config(
        input logic [GAIN_W-1:0] exc_gain,
        input logic [GAIN_W-1:0] inh_gain,
        input logic [GAIN_W-1:0] pull
    );
        apb_write(REG_EXCITE_GAIN, {17'($urandom), exc_gain});
        apb_write(REG_INHIBIT_GAIN, {17'($urandom), inh_gain});
        apb_write(REG_PULL_RATE, {17'($urandom), pull});
        check_config_readback();
    endtask

    task automatic send_item(
        input logic signed [DATA_W-1:0] exc,
        input logic signed [DATA_W-1:0] inh
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.excite_value  <= exc;
        req_ch.inhibit_value <= inh;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // called at the step of the last acceptance
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_activity.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_level();
        int v;
        v = int'($urandom_range(4096)) - 2048;
        case ($urandom_range(9))
            0:          return 16'sh8000;
            1:          return 16'sh7FFF;
            2, 3, 4, 5: return DATA_W'(v);
            default:    return DATA_W'($urandom);
        endcase
    endfunction

    // with all gains and pull at 1.0 the new activity is 1.0 + exc - inh,
    // so a tick can be aimed at exact values around the threshold
    task automatic build_plan();
        int   targets [UNITS];
        int   kind;
        int   top;
        int   inh_at;
        int   inh_amt;
        int   k;
        logic all_low;
        kind       = $urandom_range(9);
        plan_noise = !aim_mode || kind < 2;
        plan_quiet = ($urandom_range(9) < 6);
        if (!plan_noise)
        begin
            all_low = (kind == 2);
            for (k = 0; k < UNITS; k++)
                targets[k] = all_low ? -int'($urandom_range(20000, 200))
                                     : int'($urandom_range(11600)) - 8000;
            case ($urandom_range(4))
                0:       top = int'(WIN_THRESHOLD) - 1;
                1:       top = int'(WIN_THRESHOLD);
                2:       top = int'(WIN_THRESHOLD) + 1;
                3:       top = int'(WIN_THRESHOLD) + 1 + int'($urandom_range(20000));
                default: top = int'($urandom_range(5600)) - 2000;
            endcase
            if (all_low)
                top = -int'($urandom_range(199, 100));
            targets[$urandom_range(UNITS - 1)] = top;
            if ($urandom_range(1) == 1)
                targets[$urandom_range(UNITS - 1)] = top;
            inh_at  = plan_quiet ? -1 : int'($urandom_range(UNITS - 1));
            inh_amt = int'($urandom_range(3000, 1)) * (($urandom_range(1) == 1) ? 1 : -1);
            for (k = 0; k < UNITS; k++)
            begin
                plan_inh[k] = (k == inh_at) ? DATA_W'(inh_amt) : '0;
                plan_exc[k] = DATA_W'(targets[k] - int'(Q_ONE) + ((k == inh_at) ? inh_amt : 0));
            end
        end
    endtask

    task automatic make_item(
        output logic signed [DATA_W-1:0] exc,
        output logic signed [DATA_W-1:0] inh
    );
        if (gen_pos == 0)
            build_plan();
        if (plan_noise)
        begin
            exc = pick_level();
            inh = (plan_quiet || $urandom_range(1) == 0) ? '0 : pick_level();
        end
        else
        begin
            exc = plan_exc[gen_pos];
            inh = plan_inh[gen_pos];
        end
        gen_pos = (gen_pos + 1) % UNITS;
    endtask

    initial
    begin
        int                       r;
        int                       seg;
        int                       n;
        logic signed [DATA_W-1:0] e_val;
        logic signed [DATA_W-1:0] i_val;

        for (n = 0; n < UNITS; n++)
            unit_act[n] = '0;
        elem_pos        = 0;
        run_max         = '0;
        run_max_idx     = '0;
        inh_seen        = 1'b0;
        win_latched     = 1'b0;
        win_slot        = '0;
        aim_mode        = 1'b0;
        plan_noise      = 1'b1;
        plan_quiet      = 1'b0;
        gen_pos         = 0;
        items_sent      = 0;
        items_accepted  = 0;
        results_checked = 0;
        ticks_seen      = 0;
        winner_ticks    = 0;
        cfg_writes      = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        src_idle_pct    = 21;
        snk_idle_pct    = 61;

        req_ch.valid         = 1'b0;
        req_ch.excite_value  = '0;
        req_ch.inhibit_value = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        check_config_readback();

        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (r == UNITS)
            begin
                wait_drained();
                apb_write(REG_EXCITE_GAIN, 32'h0001_7FFF);
                apb_write(REG_INHIBIT_GAIN, 32'h0000_0000);
                apb_write(REG_PULL_RATE, 32'hFFFF_8800);
                // index past the last register must leave everything alone
                apb_write(UNUSED_REG, 32'hFFFF_FFFF);
                check_config_readback();
            end
            if (stim_table[r].typed)
                known_activity.push_back('{items_sent, stim_table[r].res});
            send_item(stim_table[r].exc, stim_table[r].inh);
        end
        wait_drained();
        gen_pos = DIR_ROWS % UNITS;

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    src_idle_pct = 21;
                    snk_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct = 61;
                    snk_idle_pct = 21;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            aim_mode = (seg == 1 || seg == 3);
            case (seg)
                0:       apply_config(GAIN_W'($urandom_range(8192)), GAIN_W'($urandom_range(8192)),
                                      GAIN_W'($urandom_range(600)));
                1, 3:    apply_config(GAIN_W'(Q_ONE), GAIN_W'(Q_ONE), GAIN_W'(Q_ONE));
                2:       apply_config(GAIN_MAX, '0, GAIN_MAX);
                4:       apply_config('0, GAIN_MAX, GAIN_W'($urandom));
                default: apply_config(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
            endcase
            for (n = 0; n < SEG_ITEMS; n++)
            begin
                make_item(e_val, i_val);
                send_item(e_val, i_val);
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_activity.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_activity.size());
        end

        $display("checked %0d activity results over %0d ticks, %0d tick ends with a winner",
                 results_checked, ticks_seen, winner_ticks);
        $display("%0d register writes across %0d gain settings, three stall mixes, two hold-offs",
                 cfg_writes, SEGMENTS + 2);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/lawl_pkg.sv
hw/rtl/lawl_req_if.sv
hw/rtl/lawl_rsp_if.sv
hw/rtl/lawl_cfg.sv
hw/rtl/lawl_act_mem.sv
hw/rtl/lawl_winner.sv
hw/rtl/leaky_accumulator_winner_latch_top.sv
hw/rtl/lawl_checker.sv
bench/leaky_accumulator_winner_latch_top_tb.sv
